@@ hdl/sorted_id_table_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_id_table_defines.svh
// Assertion macros used by the checker file of the sorted id table.
// ----------------------------------------------------------------------------
`ifndef SORTED_ID_TABLE_DEFINES_SVH
`define SORTED_ID_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define SIT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_id_table check failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_id_table check failed");

`endif

@@ hdl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Widths, opcodes and defaults shared by the sorted id table files.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

	// Field widths of a command word and of a result word.
	localparam int OP_W  = 2;
	localparam int KEY_W = 31;
	localparam int POS_W = 8;

	// One table entry holds the relevance flag above the id.
	localparam int ENTRY_W = KEY_W + 1;

	// Default number of table slots.
	localparam int DEFAULT_TABLE_DEPTH = 256;

	// Command opcodes.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	typedef logic [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

@@ hdl/sit_ram.sv @@
// ----------------------------------------------------------------------------
// sit_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/sorted_id_table.sv @@
// ----------------------------------------------------------------------------
// sorted_id_table
// Table of document ids with relevance flags, kept sorted ascending by id.
// Commands insert, remove or find an id; each command gives one result word.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake         Fields
//   command   start / busy      opcode, doc_key, rel_flag
//   result    done (one cycle)  success, position, entry_count
//
// A word is taken at a clock edge with start high and busy low. Busy falls in
// the result cycle. The lookup is a binary search through the one read port of
// the table RAM, with at most floor(log2(count))+1 probes. An insert or remove
// then moves every later entry by one slot at one RAM write per cycle.
// Reset clears the entry count and the control registers, not the RAM; slots
// at or above the count are never read, so the RAM needs no clearing pass and
// the block is ready at once. The receiver cannot stall the result word.
//
`default_nettype none

module sorted_id_table
	import sit_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [OP_W-1:0]  opcode,
	input  wire logic [KEY_W-1:0] doc_key,
	input  wire logic             rel_flag,
	output logic                  done,
	output logic                  success,
	output logic [POS_W-1:0]      position,
	output logic [POS_W-1:0]      entry_count
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam logic [IW-1:0] CNT_FULL = IW'(TABLE_DEPTH - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SRCH   = 3'd1;
	localparam logic [2:0] ST_CMP    = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_MOVE   = 3'd4;
	localparam logic [2:0] ST_FINAL  = 3'd5;

	logic [2:0]      state_q;
	logic [IW-1:0]   cnt_q;
	logic [OP_W-1:0] op_q;
	key_t            key_q;
	logic            flag_q;
	logic [IW-1:0]   lo_q;
	logic [IW-1:0]   hi_q;
	logic [IW-1:0]   mid_q;
	logic [IW-1:0]   pos_q;
	logic            found_q;
	logic [IW-1:0]   src_q;
	logic [IW-1:0]   dst_q;
	logic [IW-1:0]   last_q;
	logic            more_q;
	logic            pend_q;
	logic            done_q;
	logic            success_q;
	logic [POS_W-1:0] position_q;
	logic [POS_W-1:0] count_q;

	logic [IW-1:0]      mid;
	logic               is_insert;
	key_t               rd_key;
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// Search midpoint and decoded read data.
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign is_insert = (op_q == OP_INSERT);
	assign rd_key    = ram_rdata[KEY_W-1:0];

	// Table RAM port control for search probes, entry moves and the final write.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid;
		ram_we    = 1'b0;
		ram_waddr = dst_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			ST_SRCH: begin
				ram_re = (lo_q < hi_q);
			end
			ST_MOVE: begin
				ram_re    = more_q;
				ram_raddr = src_q;
				ram_we    = pend_q;
			end
			ST_FINAL: begin
				ram_we = 1'b1;
				if (is_insert) begin
					ram_waddr = pos_q;
					ram_wdata = {flag_q, key_q};
				end else begin
					ram_waddr = cnt_q - 1'b1;
					ram_wdata = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Command sequencer: binary search, then entry moves, then the final write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			op_q       <= '0;
			key_q      <= '0;
			flag_q     <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			pos_q      <= '0;
			found_q    <= 1'b0;
			src_q      <= '0;
			dst_q      <= '0;
			last_q     <= '0;
			more_q     <= 1'b0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			success_q  <= 1'b0;
			position_q <= '0;
			count_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						key_q   <= doc_key;
						flag_q  <= rel_flag;
						lo_q    <= '0;
						hi_q    <= cnt_q;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else begin
						// Search range empty: lo is the sorted slot for the key.
						found_q <= 1'b0;
						pos_q   <= lo_q;
						state_q <= ST_DECIDE;
					end
				end
				ST_CMP: begin
					if (rd_key == key_q) begin
						found_q <= 1'b1;
						pos_q   <= mid_q;
						state_q <= ST_DECIDE;
					end else if (rd_key < key_q) begin
						lo_q    <= mid_q + 1'b1;
						state_q <= ST_SRCH;
					end else begin
						hi_q    <= mid_q;
						state_q <= ST_SRCH;
					end
				end
				ST_DECIDE: begin
					more_q <= 1'b1;
					pend_q <= 1'b0;
					unique case (op_q)
						OP_INSERT: begin
							if (found_q || (cnt_q == CNT_FULL)) begin
								done_q     <= 1'b1;
								success_q  <= 1'b0;
								position_q <= '0;
								count_q    <= POS_W'(cnt_q);
								state_q    <= ST_IDLE;
							end else if (cnt_q == pos_q) begin
								state_q <= ST_FINAL;
							end else begin
								src_q   <= cnt_q - 1'b1;
								last_q  <= pos_q;
								state_q <= ST_MOVE;
							end
						end
						OP_REMOVE: begin
							if (!found_q) begin
								done_q     <= 1'b1;
								success_q  <= 1'b0;
								position_q <= '0;
								count_q    <= POS_W'(cnt_q);
								state_q    <= ST_IDLE;
							end else if (pos_q == cnt_q - 1'b1) begin
								state_q <= ST_FINAL;
							end else begin
								src_q   <= pos_q + 1'b1;
								last_q  <= cnt_q - 1'b1;
								state_q <= ST_MOVE;
							end
						end
						OP_FIND: begin
							done_q     <= 1'b1;
							success_q  <= found_q;
							position_q <= found_q ? POS_W'(pos_q) : '0;
							count_q    <= POS_W'(cnt_q);
							state_q    <= ST_IDLE;
						end
						default: begin
							// Unused opcode: no change, failure result.
							done_q     <= 1'b1;
							success_q  <= 1'b0;
							position_q <= '0;
							count_q    <= POS_W'(cnt_q);
							state_q    <= ST_IDLE;
						end
					endcase
				end
				ST_MOVE: begin
					// Read one entry per cycle; its data is written one slot over
					// in the next cycle while the following read goes out.
					if (more_q) begin
						pend_q <= 1'b1;
						dst_q  <= is_insert ? src_q + 1'b1 : src_q - 1'b1;
						src_q  <= is_insert ? src_q - 1'b1 : src_q + 1'b1;
						more_q <= (src_q != last_q);
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					done_q     <= 1'b1;
					success_q  <= 1'b1;
					position_q <= POS_W'(pos_q);
					if (is_insert) begin
						cnt_q   <= cnt_q + 1'b1;
						count_q <= POS_W'(cnt_q + 1'b1);
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						count_q <= POS_W'(cnt_q - 1'b1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table storage: flag and id in one word per slot.
	sit_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Port outputs.
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign success     = success_q;
	assign position    = position_q;
	assign entry_count = count_q;

endmodule

`default_nettype wire

@@ hdl/sit_checker.sv @@
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks of the sorted id table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_id_table_defines.svh"

module sit_checker
	import sit_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic [OP_W-1:0]  opcode,
	input wire logic             done,
	input wire logic             success,
	input wire logic [POS_W-1:0] position,
	input wire logic [POS_W-1:0] entry_count
);

	// An accepted word always makes the block busy in the next cycle.
	`SIT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// The result word appears only once the block has finished its work.
	`SIT_ASSERT_SAME(a_done_idle, done, !busy)

	// A result strobe lasts one cycle.
	`SIT_ASSERT_NEXT(a_done_pulse, done, !done)

	// A failed command reports position zero.
	`SIT_ASSERT_SAME(a_fail_pos, done && !success, position == '0)

	// A found entry sits below the reported count.
	`SIT_ASSERT_SAME(a_found_range,
		done && success && $past(opcode) == OP_FIND && !$past(start),
		position < entry_count)

endmodule

bind sorted_id_table sit_checker u_sit_checker (.*);

`default_nettype wire
